[sv/pls_pkg.sv]
package pls_pkg;

  localparam int MaxPoints  = 64;
  localparam int Coords     = 4;
  localparam int CoordWidth = 32;
  localparam int CntW       = $clog2(MaxPoints + 1);
  localparam int IdxW       = $clog2(MaxPoints);

  localparam logic [0:0] RegStrength = 1'b0;
  localparam logic [0:0] RegDims     = 1'b1;

  localparam logic [15:0] AlphaMin = 16'd9175;
  localparam logic [15:0] AlphaMax = 16'd18022;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic signed [31:0] in_coord_0;
    logic signed [31:0] in_coord_1;
    logic signed [31:0] in_coord_2;
    logic signed [31:0] in_coord_3;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_coord_0;
    logic signed [31:0] out_coord_1;
    logic signed [31:0] out_coord_2;
    logic signed [31:0] out_coord_3;
    logic               last_result;
    logic [3:0]         passes_used;
    logic [31:0]        peak_shift;
    logic               overflow;
  } out_word_t;

  // Control that every cell sees in the same cycle.
  typedef struct packed {
    logic        load;   // shift a new point in at the tail
    logic        rot;    // rotate the ring by one position
    logic        blend;  // apply the blend while rotating
    logic        first;  // head word is the polyline's first point
    logic        lastp;  // head word is the polyline's last point
    logic [15:0] alpha;
    logic [2:0]  dims;
  } cell_ctl_t;

  // Blend of one coordinate: floor((2c(32768-a) + (l+r)a + 32768) / 65536).
  function automatic coord_t blend_fn(coord_t c, coord_t l, coord_t r, logic [15:0] a);
    logic signed [50:0] p1;
    logic signed [50:0] p2;
    logic signed [50:0] s;
    p1 = 51'(c) * 51'(signed'({1'b0, 16'd32768 - a})) * 51'sd2;
    p2 = (51'(l) + 51'(r)) * 51'(signed'({1'b0, a}));
    s  = p1 + p2 + 51'sd32768;
    return coord_t'(s >>> 16);
  endfunction

endpackage

[sv/pls_cell.sv]
// One point slot of the ring: holds the original and the working coordinates.
module pls_cell import pls_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  coord_t    orig_in_i  [Coords],
  input  coord_t    work_in_i  [Coords],
  output coord_t    orig_q_o   [Coords],
  output coord_t    work_q_o   [Coords]
);

  coord_t orig_q [Coords];
  coord_t work_q [Coords];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load || ctl_i.rot) begin
      orig_q <= orig_in_i;
      work_q <= work_in_i;
    end
  end

  assign orig_q_o = orig_q;
  assign work_q_o = work_q;

endmodule

[sv/pls_disp.sv]
// Squared distance and rounded square root, one result bit per cycle.
module pls_disp import pls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  coord_t      orig_i [Coords],
  input  coord_t      work_i [Coords],
  input  logic [2:0]  dims_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001, P_SQ = 4'b0010, P_SUM = 4'b0100, P_ROOT = 4'b1000
  } disp_ph_e;

  disp_ph_e    ph_q, ph_d;
  logic [65:0] sq_q [Coords];
  logic [65:0] rem_q, rem_d;
  logic [33:0] res_q, res_d;
  logic [5:0]  k_q, k_d;
  logic [67:0] sum_w;
  logic [65:0] trial;
  logic [33:0] r;

  always_comb begin
    sum_w = '0;
    for (int c = 0; c < Coords; c++) begin
      if (c < 32'(dims_i)) sum_w = sum_w + 68'(sq_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < Coords; c++) begin
      logic signed [32:0] df;
      logic [32:0] ad;
      df = 33'(orig_i[c]) - 33'(work_i[c]);
      ad = df[32] ? 33'(-df) : 33'(df);
      sq_q[c] <= 66'(ad) * 66'(ad);
    end
  end

  always_comb begin
    ph_d = ph_q; rem_d = rem_q; res_d = res_q; k_d = k_q; done_o = 1'b0;
    trial = (66'(res_q) << 2) | 66'd1;
    r = res_q;
    unique case (ph_q)
      P_IDLE: if (start_i) ph_d = P_SQ;
      P_SQ: ph_d = P_SUM;
      P_SUM: begin
        // saturate the sum of squares at 64 bits
        rem_d = (sum_w[67:64] != 4'd0) ? 66'h0_FFFF_FFFF_FFFF_FFFF : sum_w[65:0];
        res_d = '0; k_d = 6'd32; ph_d = P_ROOT;
      end
      default: begin
        if (k_q != 0) begin
          if ((rem_q >> (2 * (k_q - 6'd1))) >= trial) begin
            rem_d = rem_q - (trial << (2 * (k_q - 6'd1)));
            res_d = (res_q << 1) | 34'd1;
          end else begin
            res_d = res_q << 1;
          end
          k_d = k_q - 6'd1;
        end else begin
          done_o = 1'b1; ph_d = P_IDLE;
        end
      end
    endcase
    if (rem_q > 66'(r)) r = res_q + 34'd1;
    root_o = (r > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE; k_q <= '0;
    end else begin
      ph_q <= ph_d; k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d;
  end

endmodule

[sv/polyline_laplacian_smoother.sv]
// A polyline of n points loads one point per cycle while busy is low; after its
// last point the block runs P smoothing passes of n rotation steps each and n
// displacement steps, one square root per point, then emits the n result words
// back to back.
// Two points or fewer skip to emission. busy stays high until the last result;
// the receiver cannot stall. Reset clears control and restores config defaults.
module polyline_laplacian_smoother import pls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word_i,
  output logic        result_valid_o,
  output out_word_t   result_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001, S_PASS = 5'b00010, S_DISP = 5'b00100,
    S_WAIT = 5'b01000, S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic signed [15:0] strength_q;
  logic [2:0]  dims_cfg_q;
  logic [CntW-1:0] cnt_q, cnt_d;       // stored points
  logic [CntW-1:0] pos_q, pos_d;       // rotation position within a pass
  logic [3:0]  pass_q, pass_d, npass_q, npass_d;
  logic        drop_q, drop_d;
  logic [31:0] best_q, best_d;
  coord_t      prev_q [Coords];         // old value of the previous point
  coord_t      head_next [Coords];      // head word as it enters the tail
  logic        disp_start, disp_done;
  logic        wait_q;
  logic [31:0] root;

  coord_t orig_q [MaxPoints][Coords];
  coord_t work_q [MaxPoints][Coords];
  coord_t orig_in [MaxPoints][Coords];
  coord_t work_in [MaxPoints][Coords];
  cell_ctl_t ctl;

  logic [2:0]  dims_eff;
  logic [15:0] alpha_w;
  logic [3:0]  npass_w;
  logic [27:0] prod;

  assign dims_eff = (dims_cfg_q == 3'd0) ? 3'd1 :
                    (dims_cfg_q > 3'(Coords)) ? 3'(Coords) : dims_cfg_q;

  // Pass count and blend factor from strength.
  always_comb begin
    logic [8:0] p;
    logic [27:0] a;
    prod = 28'(strength_q) * 28'd1147 + 28'd128;
    p = 9'(({1'b0, strength_q} + 17'sd128) >>> 8);
    if (strength_q < 16'sd256) npass_w = 4'd2;
    else if (p > 9'd8) npass_w = 4'd8;
    else if (p < 9'd2) npass_w = 4'd2;
    else npass_w = p[3:0];
    a = 28'(AlphaMin) + (prod >> 8);
    if (strength_q <= 16'sd0) alpha_w = AlphaMin;
    else if (a > 28'(AlphaMax)) alpha_w = AlphaMax;
    else alpha_w = a[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= 16'sd256; dims_cfg_q <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStrength: strength_q <= cfg_data_i;
        default:     dims_cfg_q <= cfg_data_i[2:0];
      endcase
    end
  end

  wire accept = start && !busy;
  assign busy = (state_q != S_LOAD);

  // Ring: head is cell 0, tail is cell cnt-1. Load shifts in at the chosen slot;
  // rotate moves head to tail so every cell hands its word to its neighbor.
  always_comb begin
    ctl.load  = accept && (cnt_q < CntW'(MaxPoints));
    ctl.rot   = 1'b0;
    ctl.blend = 1'b0;
    ctl.first = (pos_q == '0);
    ctl.lastp = (pos_q == cnt_q - CntW'(1));
    ctl.alpha = alpha_w;
    ctl.dims  = dims_eff;
    unique case (state_q)
      S_PASS: begin ctl.rot = 1'b1; ctl.blend = 1'b1; end
      S_DISP: ctl.rot = disp_done;
      S_EMIT: ctl.rot = 1'b1;
      default: ;
    endcase
  end

  // Blend the head once per coordinate; interior points only, leading dims only.
  always_comb begin
    for (int c = 0; c < Coords; c++) begin
      head_next[c] = work_q[0][c];
      if (ctl.blend && !ctl.first && !ctl.lastp && c < 32'(ctl.dims))
        head_next[c] = blend_fn(work_q[0][c], prev_q[c], work_q[1][c], ctl.alpha);
    end
  end

  for (genvar i = 0; i < MaxPoints; i++) begin : g_cell
    always_comb begin
      for (int c = 0; c < Coords; c++) begin
        coord_t nb;
        nb = coord_t'(0);
        if (ctl.load) begin
          // Load: the new word enters at the slot after the last stored point.
          orig_in[i][c] = orig_q[i][c];
          work_in[i][c] = work_q[i][c];
          if (cnt_q[IdxW-1:0] == IdxW'(i) ) begin
            unique case (c)
              0: nb = in_word_i.in_coord_0;
              1: nb = in_word_i.in_coord_1;
              2: nb = in_word_i.in_coord_2;
              default: nb = in_word_i.in_coord_3;
            endcase
            orig_in[i][c] = nb; work_in[i][c] = nb;
          end
        end else if (32'(i) + 1 < 32'(cnt_q) ) begin
          orig_in[i][c] = orig_q[i+1 < MaxPoints ? i+1 : i][c];
          work_in[i][c] = work_q[i+1 < MaxPoints ? i+1 : i][c];
        end else begin
          // Tail takes the head word, blended if this is a pass.
          orig_in[i][c] = orig_q[0][c];
          work_in[i][c] = head_next[c];
        end
      end
    end
    pls_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .orig_in_i (orig_in[i]),
      .work_in_i (work_in[i]),
      .orig_q_o  (orig_q[i]),
      .work_q_o  (work_q[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ctl.rot) prev_q <= work_q[0];
  end

  // Start one root per head point; hold off while one is in flight.
  assign disp_start = (state_q == S_DISP) && !disp_done && !wait_q;

  pls_disp u_disp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (disp_start),
    .orig_i  (orig_q[0]),
    .work_i  (work_q[0]),
    .dims_i  (dims_eff),
    .done_o  (disp_done),
    .root_o  (root)
  );

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pos_d = pos_q; pass_d = pass_q;
    npass_d = npass_q; drop_d = drop_q; best_d = best_q;
    result_valid_o = 1'b0;
    result_o = '0;
    result_o.out_coord_0 = work_q[0][0];
    result_o.out_coord_1 = work_q[0][1];
    result_o.out_coord_2 = work_q[0][2];
    result_o.out_coord_3 = work_q[0][3];
    unique case (state_q)
      S_LOAD: if (accept) begin
        if (ctl.load) cnt_d = cnt_q + CntW'(1);
        else drop_d = 1'b1;
        if (in_word_i.last_point) begin
          pos_d = '0; pass_d = 4'd0; best_d = '0;
          if ((ctl.load ? cnt_q + CntW'(1) : cnt_q) > CntW'(2)) begin
            npass_d = npass_w; state_d = S_PASS;
          end else begin
            npass_d = 4'd0; state_d = S_EMIT;
          end
        end
      end
      S_PASS: begin
        if (pos_q == cnt_q - CntW'(1)) begin
          pos_d = '0; pass_d = pass_q + 4'd1;
          if (pass_q + 4'd1 == npass_q) state_d = S_DISP;
        end else pos_d = pos_q + CntW'(1);
      end
      S_DISP: if (disp_done) begin
        if (root > best_q) best_d = root;
        if (pos_q == cnt_q - CntW'(1)) begin
          pos_d = '0; state_d = S_EMIT;
        end else pos_d = pos_q + CntW'(1);
      end
      S_EMIT: begin
        result_valid_o = 1'b1;
        if (pos_q == cnt_q - CntW'(1)) begin
          result_o.last_result = 1'b1;
          result_o.passes_used = npass_q;
          result_o.peak_shift = best_q;
          result_o.overflow = drop_q;
          cnt_d = '0; drop_d = 1'b0; pos_d = '0; state_d = S_LOAD;
        end else pos_d = pos_q + CntW'(1);
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; cnt_q <= '0; pos_q <= '0; pass_q <= '0;
      npass_q <= '0; drop_q <= 1'b0; best_q <= '0; wait_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; pos_q <= pos_d; pass_q <= pass_d;
      npass_q <= npass_d; drop_q <= drop_d; best_q <= best_d;
      // Hold off a new root while one is in flight.
      wait_q <= disp_start ? 1'b1 : (disp_done ? 1'b0 : wait_q);
    end
  end

endmodule
